/* rtl/line_scan_readout_peak_finder_assert.svh */
// Assertion macros shared by the line-scan readout checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef LINE_SCAN_READOUT_PEAK_FINDER_ASSERT_SVH
`define LINE_SCAN_READOUT_PEAK_FINDER_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define LSRPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsrpf assertion failed");

// Next-cycle implication, off while reset is held
`define LSRPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrpf assertion failed");

`endif

/* rtl/lsrpf_pkg.sv */
// Shared types and constants for the line-scan readout peak finder.
// No dependencies.
package lsrpf_pkg;

    // Event codes carried in the input word's tuser
    localparam logic [1:0] CMD_PHASE = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_CONV  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 10;
    localparam logic [0:0] REG_EDGE_IGNORE = 1'd0;
    localparam logic [0:0] REG_CLOCK_LIMIT = 1'd1;

    // Fixed limits and reset values
    localparam logic [6:0] INDEX_MAX        = 7'd127;
    localparam logic [9:0] COUNT_MAX        = 10'd1023;
    localparam logic [6:0] INDEX_RESET      = 7'd63;
    localparam logic [5:0] EDGE_RESET       = 6'd10;
    localparam logic [9:0] CLOCK_LIMIT_RESET = 10'd256;

    // Port widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] sample;
    } item_t;

    typedef struct packed {
        logic [6:0] line_position;
        logic       phase_period_select;
        logic       pixel_clock_run;
        logic       start_conversion;
        logic       si_level;
        logic       clk_level;
    } result_t;

endpackage

/* rtl/line_scan_readout_peak_finder.sv */
// Top level of the line-scan readout peak finder.
// Depends on lsrpf_pkg, lsrpf_in_reg and lsrpf_engine.
//
// Takes one event word per clock while m_tready stays high, and gives one result
// word per event, in order. The path runs through an input register, then the state
// update and result register. Every event is handled by one update of the sequencing
// and peak state, which sets the rate of one per clock. The event code travels in
// s_tuser, the converter sample in s_tdata. A stalled m_tready holds the result and,
// once the input register is full as well, drops s_tready. Configuration writes are
// taken in any cycle and should be made only while no event is in flight.
module line_scan_readout_peak_finder #(
    parameter int PIXEL_COUNT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Event input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lsrpf_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] sample
    input  logic [lsrpf_pkg::S_TUSER_W-1:0]     s_tuser,   // [1:0] cmd
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] clk_level, [1] si_level, [2] start_conversion, [3] pixel_clock_run,
    // [4] phase_period_select, [11:5] line_position, [15:12] zero
    output logic [lsrpf_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [lsrpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsrpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lsrpf_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;

    logic    m_valid_reg;
    logic    m_valid_next;
    result_t m_data_reg;

    assign s_item.cmd    = s_tuser;
    assign s_item.sample = s_tdata;

    // Held word moves on when the result register is free or draining
    assign advance = item_valid && (!m_valid_reg || m_tready);

    lsrpf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lsrpf_engine #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    // Result register
    assign m_valid_next = advance || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, m_data_reg};

endmodule

/* rtl/lsrpf_in_reg.sv */
// Input holding register for the readout peak finder.
// Depends on lsrpf_pkg.
module lsrpf_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lsrpf_pkg::item_t s_item,
    input  logic             take,
    output logic             item_valid,
    output lsrpf_pkg::item_t item
);
    import lsrpf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held word moves on this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/lsrpf_engine.sv */
// Sensor sequencing state, peak tracking and configuration registers.
// Depends on lsrpf_pkg.
module lsrpf_engine #(
    parameter int PIXEL_COUNT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsrpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsrpf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                step,
    input  lsrpf_pkg::item_t                    item,
    output lsrpf_pkg::result_t                  result
);
    import lsrpf_pkg::*;

    // Last usable pixel, capped by the 7-bit index
    localparam logic [9:0] LAST_PIXEL =
        (PIXEL_COUNT - 1 > 127) ? 10'd127 : 10'(PIXEL_COUNT - 1);

    typedef enum logic [3:0] {
        PH_START    = 4'b0001,
        PH_SET_CLK  = 4'b0010,
        PH_CLEAR_SI = 4'b0100,
        PH_FINAL    = 4'b1000
    } phase_t;

    logic [5:0] edge_reg;
    logic [9:0] limit_reg;

    phase_t     phase_reg,     phase_next;
    logic [9:0] count_reg,     count_next;
    logic [7:0] peak_val_reg,  peak_val_next;
    logic [6:0] peak_idx_reg,  peak_idx_next;
    logic [6:0] line_reg,      line_next;
    logic       clk_pin_reg,   clk_pin_next;
    logic       si_pin_reg,    si_pin_next;
    logic       run_reg,       run_next;
    logic       period_reg,    period_next;
    logic       conv;

    logic [9:0] pix;
    logic [9:0] edge_ext;
    logic [9:0] upper;
    logic       in_window;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg  <= EDGE_RESET;
            limit_reg <= CLOCK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_EDGE_IGNORE)
            begin
                edge_reg <= cfg_data[5:0];
            end
            if (cfg_index == REG_CLOCK_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Sample window: pixel index is half the clock count
    assign pix       = {1'b0, count_reg[9:1]};
    assign edge_ext  = {4'b0, edge_reg};
    assign upper     = LAST_PIXEL - edge_ext;
    assign in_window = (count_reg < limit_reg) && (pix > edge_ext) &&
                       (LAST_PIXEL >= edge_ext) && (pix < upper);

    // Next state for one event
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        peak_val_next = peak_val_reg;
        peak_idx_next = peak_idx_reg;
        line_next     = line_reg;
        clk_pin_next  = clk_pin_reg;
        si_pin_next   = si_pin_reg;
        run_next      = run_reg;
        period_next   = period_reg;
        conv          = 1'b0;

        case (item.cmd)
            CMD_PHASE:
            begin
                run_next = 1'b0;
                case (phase_reg)
                    PH_START:
                    begin
                        clk_pin_next  = 1'b0;
                        line_next     = peak_idx_reg;
                        si_pin_next   = 1'b1;
                        count_next    = 10'd1;
                        period_next   = 1'b0;
                        peak_val_next = 8'd0;
                        phase_next    = PH_SET_CLK;
                    end
                    PH_SET_CLK:
                    begin
                        clk_pin_next = 1'b1;
                        phase_next   = PH_CLEAR_SI;
                    end
                    PH_CLEAR_SI:
                    begin
                        si_pin_next = 1'b0;
                        phase_next  = PH_FINAL;
                    end
                    default:
                    begin
                        clk_pin_next = 1'b0;
                        period_next  = 1'b1;
                        conv         = 1'b1;
                        run_next     = 1'b1;
                        phase_next   = PH_START;
                    end
                endcase
            end
            CMD_PIXEL:
            begin
                conv         = !count_reg[0];
                clk_pin_next = !clk_pin_reg;
                if (count_reg < COUNT_MAX)
                begin
                    count_next = count_reg + 10'd1;
                end
            end
            CMD_CONV:
            begin
                if (in_window && (item.sample > peak_val_reg))
                begin
                    peak_val_next = item.sample;
                    peak_idx_next = pix[6:0] & INDEX_MAX;
                end
            end
            default:
            begin
                conv = 1'b0;
            end
        endcase
    end

    // State registers, updated once per event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            count_reg    <= 10'd0;
            peak_val_reg <= 8'd0;
            peak_idx_reg <= INDEX_RESET;
            line_reg     <= INDEX_RESET;
            clk_pin_reg  <= 1'b1;
            si_pin_reg   <= 1'b0;
            run_reg      <= 1'b0;
            period_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            peak_val_reg <= peak_val_next;
            peak_idx_reg <= peak_idx_next;
            line_reg     <= line_next;
            clk_pin_reg  <= clk_pin_next;
            si_pin_reg   <= si_pin_next;
            run_reg      <= run_next;
            period_reg   <= period_next;
        end
    end

    // Levels after the event
    assign result.clk_level           = clk_pin_next;
    assign result.si_level            = si_pin_next;
    assign result.start_conversion    = conv;
    assign result.pixel_clock_run     = run_next;
    assign result.phase_period_select = period_next;
    assign result.line_position       = line_next;

endmodule

/* rtl/lsrpf_checker.sv */
// Port-level checks for the line-scan readout peak finder, bound to the top.
// Depends on line_scan_readout_peak_finder_assert.svh.
`include "line_scan_readout_peak_finder_assert.svh"

module lsrpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result word holds
    `LSRPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input back-pressure only when the result side is stalled
    `LSRPF_ASSERT_NOW(a_in_stall, !s_tready, m_tvalid && !m_tready)

    // SI is high only in the early start phases, with the pixel clock stopped
    `LSRPF_ASSERT_NOW(a_si_timer, m_tvalid && m_tdata[1], !m_tdata[3])

    // Pixel clock runs only after the final phase chose the integration period
    `LSRPF_ASSERT_NOW(a_run_period, m_tvalid && m_tdata[3], m_tdata[4])

endmodule

bind line_scan_readout_peak_finder lsrpf_checker u_lsrpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb_top.sv */
// Self-checking bench for the line-scan readout peak finder: drives scan sequences,
// noise and register settings, and checks every result word against its own predictor.
// Depends on lsrpf_pkg and line_scan_readout_peak_finder.
module tb_top;
    import lsrpf_pkg::*;

    localparam int PIXELS         = 128;
    localparam int LAST_PIXEL     = (PIXELS - 1 > 127) ? 127 : PIXELS - 1;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 700;
    localparam int SIDE_TX        = 0;
    localparam int SIDE_RX        = 1;
    localparam int SETTINGS_N     = 6;

    typedef enum logic [1:0] {
        SEQ_START,
        SEQ_SET_CLK,
        SEQ_CLEAR_SI,
        SEQ_FINAL
    } seq_phase_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [7:0] sample
    logic [S_TUSER_W-1:0]   s_tuser   = '0;   // [1:0] cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] clk_level, [1] si_level, [2] start_conversion, [3] pixel_clock_run,
    // [4] phase_period_select, [11:5] line_position, [15:12] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted sensor state and register copies
    int          ignore_cfg;
    int          limit_cfg;
    seq_phase_t  seq_phase;
    logic [9:0]  clock_count;
    logic [7:0]  peak_value;
    logic [6:0]  peak_index;
    logic [6:0]  published_line;
    logic        clk_pin;
    logic        si_pin;
    logic        timer_on;
    logic        period_sel;

    // Queues and bookkeeping
    item_t   pending_events[$];
    result_t predicted_words[$];
    int      events_queued   = 0;
    int      events_taken    = 0;
    int      results_checked = 0;
    int      mismatches      = 0;
    int      scans_queued    = 0;
    int      phases_queued   = 0;
    int      peak_updates    = 0;
    int      ceiling_hits    = 0;
    int      idle_cycles     = 0;
    int      calm_left[2]    = '{0, 0};
    int      tx_gap          = 0;
    int      rx_stall        = 0;
    int      hold_left       = 0;
    bit      pressure_done   = 1'b0;
    logic    in_taken        = 1'b0;
    logic    out_taken       = 1'b0;

    line_scan_readout_peak_finder #(.PIXEL_COUNT(PIXELS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one event to the predicted state and return the levels it leaves
    function automatic result_t advance_sensor(item_t ev);
        result_t r;
        logic    conv;
        int      p;
        conv = 1'b0;
        case (ev.cmd)
            CMD_PHASE:
            begin
                timer_on = 1'b0;
                case (seq_phase)
                    SEQ_START:
                    begin
                        clk_pin        = 1'b0;
                        published_line = peak_index;
                        si_pin         = 1'b1;
                        clock_count    = 10'd1;
                        period_sel     = 1'b0;
                        peak_value     = 8'd0;
                        seq_phase      = SEQ_SET_CLK;
                    end
                    SEQ_SET_CLK:
                    begin
                        clk_pin   = 1'b1;
                        seq_phase = SEQ_CLEAR_SI;
                    end
                    SEQ_CLEAR_SI:
                    begin
                        si_pin    = 1'b0;
                        seq_phase = SEQ_FINAL;
                    end
                    default:
                    begin
                        clk_pin    = 1'b0;
                        period_sel = 1'b1;
                        conv       = 1'b1;
                        timer_on   = 1'b1;
                        seq_phase  = SEQ_START;
                    end
                endcase
            end
            CMD_PIXEL:
            begin
                // conversion on even counts, count sticks at its ceiling
                conv    = ~clock_count[0];
                clk_pin = ~clk_pin;
                if (clock_count < COUNT_MAX)
                    clock_count = clock_count + 10'd1;
                else
                    ceiling_hits++;
            end
            CMD_CONV:
            begin
                p = int'(clock_count) >> 1;
                if (int'(clock_count) < limit_cfg && p > ignore_cfg &&
                    LAST_PIXEL >= ignore_cfg && p < LAST_PIXEL - ignore_cfg &&
                    ev.sample > peak_value)
                begin
                    peak_value = ev.sample;
                    peak_index = p[6:0];
                    peak_updates++;
                end
            end
            default: ;   // unused code: levels only, no conversion
        endcase
        r.clk_level           = clk_pin;
        r.si_level            = si_pin;
        r.start_conversion    = conv;
        r.pixel_clock_run     = timer_on;
        r.phase_period_select = period_sel;
        r.line_position       = published_line;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Gap length for either side: mostly short, a few long, calm stretches now and then
    function automatic int idle_len(int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void queue_event(logic [1:0] cmd, logic [7:0] sample);
        item_t ev;
        ev.cmd    = cmd;
        ev.sample = sample;
        pending_events.push_back(ev);
        events_queued++;
        if (cmd == CMD_PHASE)
            phases_queued++;
    endfunction

    // One scan: realign the start sequence, run it, then clock pixels and answer
    // conversion requests, with stray events and broken starts mixed in when noisy
    function automatic void queue_scan(int pixels, int conv_pct, bit noisy);
        int n_phase;
        scans_queued++;
        while (phases_queued % 4 != 0)
            queue_event(CMD_PHASE, 8'($urandom_range(0, 255)));
        n_phase = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
        repeat (n_phase)
            queue_event(CMD_PHASE, 8'($urandom_range(0, 255)));
        queue_event(CMD_CONV, 8'($urandom_range(0, 255)));
        for (int k = 1; k <= pixels; k++)
        begin
            if (noisy && $urandom_range(0, 24) == 0)
                queue_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            queue_event(CMD_PIXEL, 8'($urandom_range(0, 255)));
            if (k % 2 == 0 && $urandom_range(1, 100) <= conv_pct)
                queue_event(CMD_CONV, 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_EDGE_IGNORE)
            ignore_cfg = value & 'h3F;
        else
            limit_cfg = value & 'h3FF;
    endtask

    // Wait for every queued word to be taken and answered, then let the pipe empty
    task automatic settle();
        while (pending_events.size() != 0 || events_taken != events_queued ||
               predicted_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender: next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin : event_driver
        item_t ev;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                ev = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= ev.sample;
                s_tuser  <= ev.cmd;
                tx_gap   = idle_len(SIDE_TX);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (!pressure_done && results_checked >= HOLD_AFTER)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (out_taken && rx_stall == 0)
                rx_stall = idle_len(SIDE_RX);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Predict on each accepted event word, check each accepted result word
    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (rst_n)
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
            begin
                predicted_words.push_back(advance_sensor('{cmd: s_tuser, sample: s_tdata}));
                events_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[11:0];
                results_checked++;
                if (predicted_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("clk_level", int'(want.clk_level), int'(got.clk_level));
                    check_field("si_level", int'(want.si_level), int'(got.si_level));
                    check_field("start_conversion", int'(want.start_conversion),
                                int'(got.start_conversion));
                    check_field("pixel_clock_run", int'(want.pixel_clock_run),
                                int'(got.pixel_clock_run));
                    check_field("phase_period_select", int'(want.phase_period_select),
                                int'(got.phase_period_select));
                    check_field("line_position", int'(want.line_position),
                                int'(got.line_position));
                    check_field("padding", 0, int'(m_tdata[15:12]));
                end
            end
            // watchdog on a stuck handshake
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ignore_set[SETTINGS_N];
        int limit_set[SETTINGS_N];
        int phase_start;
        // reset values of the predicted state
        ignore_cfg     = int'(EDGE_RESET);
        limit_cfg      = int'(CLOCK_LIMIT_RESET);
        seq_phase      = SEQ_START;
        clock_count    = 10'd0;
        peak_value     = 8'd0;
        peak_index     = INDEX_RESET;
        published_line = INDEX_RESET;
        clk_pin        = 1'b1;
        si_pin         = 1'b0;
        timer_on       = 1'b0;
        period_sel     = 1'b0;
        ignore_set     = '{10, 63, 0, 30, 5, 0};
        limit_set      = '{256, 1023, 0, 150, 40, 0};
        ignore_set[SETTINGS_N-1] = int'($urandom_range(0, 1023));   // upper bits unused
        limit_set[SETTINGS_N-1]  = int'($urandom_range(0, 1023));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: unused code, pixel clock while stopped, conversion outside a scan,
        // full start sequence, window edges, equal and extreme samples, publication
        set_register(REG_EDGE_IGNORE, 0);
        set_register(REG_CLOCK_LIMIT, 1023);
        queue_event(CMD_UNUSED, 8'hFF);
        queue_event(CMD_PIXEL, 8'h00);
        queue_event(CMD_CONV, 8'hFF);
        repeat (4) queue_event(CMD_PHASE, 8'h00);
        queue_event(CMD_CONV, 8'h00);
        queue_event(CMD_PIXEL, 8'hAA);
        queue_event(CMD_PIXEL, 8'h55);
        queue_event(CMD_CONV, 8'h80);
        queue_event(CMD_CONV, 8'h80);
        queue_event(CMD_CONV, 8'hFF);
        queue_event(CMD_PIXEL, 8'h00);
        queue_event(CMD_PIXEL, 8'h00);
        queue_event(CMD_CONV, 8'h00);
        queue_event(CMD_UNUSED, 8'h00);
        repeat (8) queue_event(CMD_PHASE, 8'h00);
        settle();

        // Short random scans under a series of register settings
        for (int s = 0; s < SETTINGS_N; s++)
        begin
            set_register(REG_EDGE_IGNORE, ignore_set[s]);
            set_register(REG_CLOCK_LIMIT, limit_set[s]);
            phase_start = events_queued;
            while (events_queued - phase_start < 30)
                queue_scan($urandom_range(0, 70), 100, 1'b1);
            settle();
        end

        // One long clean scan that drives the clock count into its ceiling
        set_register(REG_EDGE_IGNORE, 0);
        set_register(REG_CLOCK_LIMIT, 1023);
        queue_scan(1030, 8, 1'b0);
        settle();

        $display("Covered %0d result words over %0d scans and %0d register settings.",
                 results_checked, scans_queued, SETTINGS_N + 2);
        $display("Peak moved %0d times; clock count held at its ceiling %0d times.",
                 peak_updates, ceiling_hits);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
